[design/nmea_autopilot_sentence_parser_defines.svh]
// ----------------------------------------------------------------------------
// nmea autopilot sentence parser assertion macros
// concurrent checks clocked by clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef NMEA_AUTOPILOT_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_AUTOPILOT_SENTENCE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define NMEAAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NMEAAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NMEAAP_ASSERT(lbl, prop, msg)
`define NMEAAP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/nmeaap_pkg.sv]
// ----------------------------------------------------------------------------
// nmea autopilot parser package
// shared types, character codes and number helpers
// ----------------------------------------------------------------------------
package nmeaap_pkg;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_APB   = 2'd1,
        KIND_RMC   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [23:0] raw_miles;
        logic               right_side;
        logic signed [23:0] course_to_steer;
        logic signed [23:0] bearing_to_waypoint;
        logic signed [23:0] heading_to_waypoint;
        logic signed [23:0] course_over_ground;
    } event_t;

    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_R     = 8'h52;

    localparam logic [23:0] ID_APB = 24'h415042;
    localparam logic [23:0] ID_RMC = 24'h524d43;

    localparam logic [3:0] FLD_MILES   = 4'd4;
    localparam logic [3:0] FLD_SIDE    = 4'd5;
    localparam logic [3:0] FLD_COURSE  = 4'd9;
    localparam logic [3:0] FLD_BEARING = 4'd12;
    localparam logic [3:0] FLD_HEADING = 4'd14;

    localparam logic [23:0] MAG_LIMIT = 24'h800000;
    localparam logic [23:0] POS_LIMIT = 24'h7fffff;

    localparam logic [10:0] MILE_FRAC  = 11'd852;
    localparam logic [30:0] RECIP_125  = 31'd1099511627;
    localparam int          RECIP_BITS = 37;

    function automatic logic [23:0] sat_mul_add(input logic [23:0] a, input logic [3:0] d);
        logic [27:0] r;
        begin
            r = {a, 3'b000} + {3'b000, a, 1'b0} + 28'(d);
            sat_mul_add = (r > 28'(MAG_LIMIT)) ? MAG_LIMIT : r[23:0];
        end
    endfunction

    function automatic logic signed [23:0] finish_number(
        input logic [23:0] acc,
        input logic        point,
        input logic [1:0]  frac,
        input logic        minus
    );
        logic [1:0]  have;
        logic [33:0] prod;
        logic [23:0] mag;
        begin
            have = point ? frac : 2'd0;
            unique case (have)
                2'd0:    prod = 34'(acc) * 34'd1000;
                2'd1:    prod = 34'(acc) * 34'd100;
                2'd2:    prod = 34'(acc) * 34'd10;
                default: prod = 34'(acc);
            endcase
            mag = (prod > 34'(MAG_LIMIT)) ? MAG_LIMIT : prod[23:0];
            if (minus)
                finish_number = 24'(-mag);
            else
                finish_number = (mag == MAG_LIMIT) ? POS_LIMIT : mag;
        end
    endfunction

endpackage

[design/nmeaap_front.sv]
// ----------------------------------------------------------------------------
// nmea autopilot parser front end
// per-character field splitting, number parsing and sentence classification
// ----------------------------------------------------------------------------
module nmeaap_front #(
    parameter int FIELD_LIMIT = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_vld,
    input  logic [7:0]            rx_byte,
    output logic                  ev_push,
    output nmeaap_pkg::event_t    ev_data
);
    import nmeaap_pkg::*;

    localparam logic [3:0] FLD_MAX = 4'(FIELD_LIMIT);

    logic [3:0]         field_num_reg, field_num_next;
    logic [2:0]         char_pos_reg, char_pos_next;
    logic [23:0]        sent_id_reg, sent_id_next;
    logic [23:0]        acc_reg, acc_next;
    logic [1:0]         frac_reg, frac_next;
    logic               point_reg, point_next;
    logic               minus_reg, minus_next;
    logic               right_reg, right_next;
    logic               after_cr_reg, after_cr_next;
    logic signed [23:0] raw_miles_reg, raw_miles_next;
    logic signed [23:0] cts_reg, cts_next;
    logic signed [23:0] btw_reg, btw_next;
    logic signed [23:0] htw_reg, htw_next;
    logic signed [23:0] cog_reg, cog_next;

    logic               is_lf;
    logic               do_end;
    logic               do_char;
    logic [3:0]         fnum;
    logic signed [23:0] fin;
    logic               is_digit;
    kind_t              kind;

    assign is_lf    = byte_vld && (rx_byte == CHAR_LF);
    assign fnum     = field_num_reg + 4'd1;
    assign fin      = finish_number(acc_reg, point_reg, frac_reg, minus_reg);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

    always_comb
    begin
        do_end  = 1'b0;
        do_char = 1'b0;
        if (byte_vld && !after_cr_reg)
        begin
            if (rx_byte == CHAR_LF)
                do_end = (char_pos_reg != 3'd0);
            else if (rx_byte == CHAR_CR || rx_byte == CHAR_COMMA)
                do_end = 1'b1;
            else
                do_char = 1'b1;
        end
    end

    always_comb
    begin
        field_num_next = field_num_reg;
        char_pos_next  = char_pos_reg;
        sent_id_next   = sent_id_reg;
        acc_next       = acc_reg;
        frac_next      = frac_reg;
        point_next     = point_reg;
        minus_next     = minus_reg;
        right_next     = right_reg;
        after_cr_next  = after_cr_reg;
        raw_miles_next = raw_miles_reg;
        cts_next       = cts_reg;
        btw_next       = btw_reg;
        htw_next       = htw_reg;
        cog_next       = cog_reg;

        // character position and identifier bytes
        if (byte_vld && !is_lf)
        begin
            unique case (char_pos_reg)
                3'd3:    sent_id_next[23:16] = rx_byte;
                3'd4:    sent_id_next[15:8]  = rx_byte;
                3'd5:    sent_id_next[7:0]   = rx_byte;
                default: sent_id_next        = sent_id_reg;
            endcase
            if (char_pos_reg != 3'd7)
                char_pos_next = char_pos_reg + 3'd1;
            if (!after_cr_reg && rx_byte == CHAR_CR)
                after_cr_next = 1'b1;
        end

        // field end
        if (do_end)
        begin
            if (field_num_reg < FLD_MAX)
            begin
                if (fnum == FLD_SIDE)
                    right_next = minus_reg && point_reg;
                else if (fnum == FLD_MILES)
                    raw_miles_next = fin;
                else if (fnum == FLD_COURSE && sent_id_reg == ID_APB)
                    cts_next = fin;
                else if (fnum == FLD_COURSE && sent_id_reg == ID_RMC)
                    cog_next = fin;
                else if (fnum == FLD_BEARING && sent_id_reg == ID_APB)
                    btw_next = fin;
                else if (fnum == FLD_HEADING && sent_id_reg == ID_APB)
                    htw_next = fin;
                field_num_next = fnum;
            end
            acc_next   = '0;
            frac_next  = '0;
            point_next = 1'b0;
            minus_next = 1'b0;
        end

        // field character
        if (do_char && field_num_reg < FLD_MAX)
        begin
            if (field_num_reg == FLD_MILES)
            begin
                if (!minus_reg)
                begin
                    point_next = (rx_byte == CHAR_R);
                    minus_next = 1'b1;
                end
                else
                begin
                    point_next = 1'b0;
                end
            end
            else if (is_digit)
            begin
                if (!point_reg)
                begin
                    acc_next = sat_mul_add(acc_reg, rx_byte[3:0]);
                end
                else if (frac_reg != 2'd3)
                begin
                    acc_next  = sat_mul_add(acc_reg, rx_byte[3:0]);
                    frac_next = frac_reg + 2'd1;
                end
            end
            else if (rx_byte == CHAR_DOT)
            begin
                point_next = 1'b1;
            end
            else if (rx_byte == CHAR_MINUS)
            begin
                minus_next = 1'b1;
            end
        end

        // new sentence after lf
        if (is_lf)
        begin
            field_num_next = '0;
            char_pos_next  = '0;
            sent_id_next   = '0;
            after_cr_next  = 1'b0;
            acc_next       = '0;
            frac_next      = '0;
            point_next     = 1'b0;
            minus_next     = 1'b0;
        end
    end

    always_comb
    begin
        priority if (char_pos_reg == 3'd0)
            kind = KIND_EMPTY;
        else if (sent_id_reg == ID_APB)
            kind = KIND_APB;
        else if (sent_id_reg == ID_RMC)
            kind = KIND_RMC;
        else
            kind = KIND_OTHER;
    end

    assign ev_push                     = is_lf;
    assign ev_data.kind                = kind;
    assign ev_data.raw_miles           = raw_miles_next;
    assign ev_data.right_side          = right_next;
    assign ev_data.course_to_steer     = cts_next;
    assign ev_data.bearing_to_waypoint = btw_next;
    assign ev_data.heading_to_waypoint = htw_next;
    assign ev_data.course_over_ground  = cog_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_num_reg <= '0;
            char_pos_reg  <= '0;
            sent_id_reg   <= '0;
            acc_reg       <= '0;
            frac_reg      <= '0;
            point_reg     <= 1'b0;
            minus_reg     <= 1'b0;
            right_reg     <= 1'b0;
            after_cr_reg  <= 1'b0;
            raw_miles_reg <= '0;
            cts_reg       <= '0;
            btw_reg       <= '0;
            htw_reg       <= '0;
            cog_reg       <= '0;
        end
        else if (byte_vld)
        begin
            field_num_reg <= field_num_next;
            char_pos_reg  <= char_pos_next;
            sent_id_reg   <= sent_id_next;
            acc_reg       <= acc_next;
            frac_reg      <= frac_next;
            point_reg     <= point_next;
            minus_reg     <= minus_next;
            right_reg     <= right_next;
            after_cr_reg  <= after_cr_next;
            raw_miles_reg <= raw_miles_next;
            cts_reg       <= cts_next;
            btw_reg       <= btw_next;
            htw_reg       <= htw_next;
            cog_reg       <= cog_next;
        end
    end

endmodule

[design/nmeaap_queue.sv]
// ----------------------------------------------------------------------------
// nmea autopilot parser event queue
// small register fifo between the front end and the back end
// ----------------------------------------------------------------------------
`include "nmea_autopilot_sentence_parser_defines.svh"

module nmeaap_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nmeaap_pkg::event_t din,
    output logic               full,
    input  logic               pop,
    output nmeaap_pkg::event_t dout,
    output logic               empty
);
    import nmeaap_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    event_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    `NMEAAP_ASSERT(a_count_bound, count_reg <= FULL_COUNT, "queue count beyond depth")
    `NMEAAP_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1), "queue count did not grow")
    `NMEAAP_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_reg == $past(count_reg) - CW'(1), "queue count did not shrink")
    `NMEAAP_ASSERT(a_ptr_gap, (count_reg == '0 || count_reg == FULL_COUNT) || (wr_ptr_reg != rd_ptr_reg), "queue pointers disagree with count")

endmodule

[design/nmeaap_back.sv]
// ----------------------------------------------------------------------------
// nmea autopilot parser back end
// cross-track conversion pipeline and result register
// ----------------------------------------------------------------------------
module nmeaap_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      linear_mode,
    input  logic signed [24:0]        kept_cross_track,
    input  logic                      q_empty,
    input  nmeaap_pkg::event_t        q_data,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                sentence_kind,
    output logic signed [23:0]        course_to_steer,
    output logic signed [23:0]        bearing_to_waypoint,
    output logic signed [23:0]        heading_to_waypoint,
    output logic signed [25:0]        cross_track,
    output logic signed [23:0]        course_over_ground
);
    import nmeaap_pkg::*;

    logic               en;
    logic               out_vld_reg;
    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg;
    event_t             s1_ev_reg, s2_ev_reg, s3_ev_reg;
    logic [23:0]        s1_abs_reg, s2_abs_reg;
    logic               s1_neg_reg, s2_neg_reg;
    logic [32:0]        s1_p_reg;
    logic [29:0]        s2_y_reg;
    logic [23:0]        s2_q_reg;
    logic signed [25:0] s3_m_reg;
    logic signed [25:0] held_xt_reg;
    event_t             out_ev_reg;
    logic signed [25:0] out_xt_reg;

    logic [23:0]        abs_raw;
    logic [32:0]        p;
    logic [29:0]        y;
    logic [60:0]        prod;
    logic [30:0]        q125;
    logic [30:0]        rem;
    logic [23:0]        q_fix;
    logic [24:0]        m_abs;
    logic signed [25:0] m_signed;
    logic signed [25:0] xt;

    assign en    = !out_vld_reg || pop;
    assign q_pop = en && !q_empty;

    assign abs_raw  = q_data.raw_miles[23] ? 24'(-q_data.raw_miles) : q_data.raw_miles;
    assign p        = 33'(abs_raw) * 33'(MILE_FRAC) + 33'd500;
    assign y        = s1_p_reg[32:3];
    assign prod     = 61'(y) * 61'(RECIP_125);
    assign q125     = {s2_q_reg, 7'b0} - {5'b0, s2_q_reg, 2'b0} + 31'(s2_q_reg);
    assign rem      = 31'(s2_y_reg) - q125;
    assign q_fix    = (rem >= 31'd125) ? s2_q_reg + 24'd1 : s2_q_reg;
    assign m_abs    = 25'(s2_abs_reg) + 25'(q_fix);
    assign m_signed = (s2_neg_reg ^ s2_ev_reg.right_side) ? -26'(m_abs) : 26'(m_abs);
    assign xt       = linear_mode ? 26'(kept_cross_track) - s3_m_reg : s3_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            held_xt_reg <= '0;
        end
        else if (en)
        begin
            s1_vld_reg  <= !q_empty;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
            if (s3_vld_reg && s3_ev_reg.kind == KIND_APB)
                held_xt_reg <= xt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ev_reg  <= q_data;
            s1_abs_reg <= abs_raw;
            s1_neg_reg <= q_data.raw_miles[23];
            s1_p_reg   <= p;
            s2_ev_reg  <= s1_ev_reg;
            s2_abs_reg <= s1_abs_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_y_reg   <= y;
            s2_q_reg   <= prod[RECIP_BITS+23:RECIP_BITS];
            s3_ev_reg  <= s2_ev_reg;
            s3_m_reg   <= m_signed;
            out_ev_reg <= s3_ev_reg;
            out_xt_reg <= (s3_ev_reg.kind == KIND_APB) ? xt : held_xt_reg;
        end
    end

    assign empty               = !out_vld_reg;
    assign sentence_kind       = out_ev_reg.kind;
    assign course_to_steer     = out_ev_reg.course_to_steer;
    assign bearing_to_waypoint = out_ev_reg.bearing_to_waypoint;
    assign heading_to_waypoint = out_ev_reg.heading_to_waypoint;
    assign cross_track         = out_xt_reg;
    assign course_over_ground  = out_ev_reg.course_over_ground;

endmodule

[design/nmea_autopilot_sentence_parser.sv]
// ----------------------------------------------------------------------------
// nmea autopilot sentence parser
// Bytes enter through a queue-like port: a transaction happens on push with
// full low. Zero bytes are dropped. Every LF yields one result, read through
// a queue-like port: while empty is low the result is on the ports and pop
// takes it. Results come out in LF order.
// Throughput is one byte per cycle while full is low, set by the per-character
// update of the front end. An LF's result reaches the result ports after it is
// registered in the event queue and passes three stages of the cross-track
// conversion (multiply by 852 and round, reciprocal divide by 1000, quotient
// correction with the raw value added and sign), then the result register.
// When pop stays low the back end holds and the event queue fills; full
// rises once QUEUE_DEPTH events wait, and byte transactions pause.
// Configuration writes (cfg_valid, always ready) take effect at once and are
// meant for an idle block. Reset clears all parse state, held values and
// configuration to zero and empties the queue and the pipeline.
// ----------------------------------------------------------------------------
module nmea_autopilot_sentence_parser #(
    parameter int FIELD_LIMIT = 15,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         sentence_kind,
    output logic signed [23:0] course_to_steer,
    output logic signed [23:0] bearing_to_waypoint,
    output logic signed [23:0] heading_to_waypoint,
    output logic signed [25:0] cross_track,
    output logic signed [23:0] course_over_ground,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [24:0]        cfg_data
);
    import nmeaap_pkg::*;

    localparam logic [0:0] REG_LINEAR_MODE = 1'b0;
    localparam logic [0:0] REG_KEPT_XTRACK = 1'b1;

    logic               linear_mode_reg;
    logic signed [24:0] kept_xt_reg;
    logic               byte_vld;
    logic               ev_push;
    event_t             ev_in;
    event_t             ev_out;
    logic               q_empty;
    logic               q_pop;

    assign cfg_ready = 1'b1;
    assign byte_vld  = push && !full && (rx_byte != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_mode_reg <= 1'b0;
            kept_xt_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LINEAR_MODE: linear_mode_reg <= cfg_data[0];
                REG_KEPT_XTRACK: kept_xt_reg     <= cfg_data;
                default:         kept_xt_reg     <= kept_xt_reg;
            endcase
        end
    end

    nmeaap_front #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_vld (byte_vld),
        .rx_byte  (rx_byte),
        .ev_push  (ev_push),
        .ev_data  (ev_in)
    );

    nmeaap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ev_push),
        .din   (ev_in),
        .full  (full),
        .pop   (q_pop),
        .dout  (ev_out),
        .empty (q_empty)
    );

    nmeaap_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .linear_mode         (linear_mode_reg),
        .kept_cross_track    (kept_xt_reg),
        .q_empty             (q_empty),
        .q_data              (ev_out),
        .q_pop               (q_pop),
        .empty               (empty),
        .pop                 (pop),
        .sentence_kind       (sentence_kind),
        .course_to_steer     (course_to_steer),
        .bearing_to_waypoint (bearing_to_waypoint),
        .heading_to_waypoint (heading_to_waypoint),
        .cross_track         (cross_track),
        .course_over_ground  (course_over_ground)
    );

endmodule
